FILE: src/fixed_timestep_accumulator_top_assert.svh
// Assertion macros shared by the checker of the tick scheduler.
// Each macro samples on the rising edge of clock and is switched off while reset is high.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_TOP_ASSERT_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTA_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fixed_timestep_accumulator_top: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fixed_timestep_accumulator_top: next-cycle check failed");

`endif

FILE: src/fta_pkg.sv
package fta_pkg;

   // Field widths of the channels.
   localparam int unsigned OpW      = 2;
   localparam int unsigned AmountW  = 64;
   localparam int unsigned StepsW   = 5;
   localparam int unsigned AccW     = 38;
   localparam int unsigned DenW     = 33;
   localparam int unsigned CntW     = 32;

   // Register widths and the configuration port.
   localparam int unsigned HzW      = 10;
   localparam int unsigned FptW     = 4;
   localparam int unsigned BudgetW  = 8;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 10;

   // Scaled gain: accumulator-sized amount times the field rate.
   localparam int unsigned GainW    = AccW + HzW;

   // Time constants.
   localparam logic [63:0] UnitsPerField      = 64'd1000000000;
   localparam int unsigned DefaultHz          = 60;
   localparam int unsigned DefaultFpt         = 2;
   localparam int unsigned MaxFieldsPerTick   = 6;
   localparam int unsigned FptEffW            = $clog2(MaxFieldsPerTick + 1);
   localparam int unsigned RebaseTicksDefault = 30;
   localparam int unsigned StepsMax           = (1 << StepsW) - 1;

   // Register reset values.
   localparam logic [HzW-1:0]     ResetHz     = HzW'(DefaultHz);
   localparam logic [FptW-1:0]    ResetFpt    = FptW'(DefaultFpt);
   localparam logic [BudgetW-1:0] ResetBudget = '0;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxW-1:0] CsrFieldRate  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrFieldsTick = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrStepBudget = 2'd2;

   // Request operations.
   typedef enum logic [OpW-1:0] {
      OP_ADV_NS  = 2'd0,
      OP_ADV_RAW = 2'd1,
      OP_REBASE  = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_STEP,
      ST_OUT
   } state_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [HzW-1:0]     field_rate_hz;
      logic [FptW-1:0]    tick_fields;
      logic [BudgetW-1:0] step_budget;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic check;
      logic sub;
      logic close;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic advance;
      logic can_sub;
   } dp_status_type;

endpackage

FILE: src/fta_ifs.sv
// Request channel: one operation and its amount.
interface fta_req_if import fta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OpW-1:0]     opcode;
   logic [AmountW-1:0] amount;

   modport source (output valid, output opcode, output amount, input ready);
   modport sink   (input valid, input opcode, input amount, output ready);
endinterface

// Response channel: one result per request.
interface fta_rsp_if import fta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [StepsW-1:0] steps;
   logic              rebased;
   logic              budget_hit;
   logic              has_debt;
   logic [AccW-1:0]   alpha_num;
   logic [DenW-1:0]   alpha_den;
   logic [CntW-1:0]   tick_total;
   logic [CntW-1:0]   catchup_total;
   logic [CntW-1:0]   skip_total;
   logic [CntW-1:0]   rebase_total;

   modport source (output valid, output steps, output rebased, output budget_hit,
                   output has_debt, output alpha_num, output alpha_den, output tick_total,
                   output catchup_total, output skip_total, output rebase_total,
                   input ready);
   modport sink   (input valid, input steps, input rebased, input budget_hit,
                   input has_debt, input alpha_num, input alpha_den, input tick_total,
                   input catchup_total, input skip_total, input rebase_total,
                   output ready);
endinterface

// Configuration write channel.
interface fta_csr_if import fta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/fta_csr.sv
module fta_csr import fta_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output logic                csr_ready,
   output cfg_type             cfg
);

   cfg_type cfg_ff;

   // Writes are always taken; an index past the register list is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_rate_hz <= ResetHz;
         cfg_ff.tick_fields   <= ResetFpt;
         cfg_ff.step_budget   <= ResetBudget;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrFieldRate:  cfg_ff.field_rate_hz <= csr_data[HzW-1:0];
            CsrFieldsTick: cfg_ff.tick_fields   <= csr_data[FptW-1:0];
            CsrStepBudget: cfg_ff.step_budget   <= csr_data[BudgetW-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/fta_ctrl.sv
module fta_ctrl import fta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencing: multiply, check, one tick per cycle, then hand the result over.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.advance ? ST_STEP : ST_OUT;
         end
         ST_STEP: begin
            if (status.can_sub) begin
               cmd.sub = 1'b1;
            end else begin
               cmd.close = 1'b1;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            // The output register is free once its previous result is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/fta_dp.sv
module fta_dp import fta_pkg::*; #(
   parameter int unsigned REBASE_TICKS = RebaseTicksDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [OpW-1:0]     req_opcode,
   input  logic [AmountW-1:0] req_amount,
   output logic [StepsW-1:0]  rsp_steps,
   output logic               rsp_rebased,
   output logic               rsp_budget_hit,
   output logic               rsp_has_debt,
   output logic [AccW-1:0]    rsp_alpha_num,
   output logic [DenW-1:0]    rsp_alpha_den,
   output logic [CntW-1:0]    rsp_tick_total,
   output logic [CntW-1:0]    rsp_catchup_total,
   output logic [CntW-1:0]    rsp_skip_total,
   output logic [CntW-1:0]    rsp_rebase_total
);

   localparam int unsigned     StepW         = $clog2(REBASE_TICKS + 1);
   localparam logic [AccW-1:0] BoundPerField = AccW'(64'(REBASE_TICKS) * UnitsPerField);

   // Persistent state.
   logic [AccW-1:0] acc_ff;
   logic [CntW-1:0] tick_cnt_ff, catchup_cnt_ff, skip_cnt_ff, rebase_cnt_ff;

   // Per-request working registers.
   op_type             op_ff;
   logic [AmountW-1:0] amt_ff;
   logic [DenW-1:0]    tu_ff;
   logic [AccW-1:0]    bound_ff;
   logic [GainW-1:0]   gain_ff;
   logic               big_ff;
   logic [StepW-1:0]   steps_ff;
   logic               rebased_ff, hit_ff;

   // Result registers.
   logic [StepsW-1:0] rsp_steps_ff;
   logic              rsp_rebased_ff, rsp_hit_ff, rsp_debt_ff;
   logic [AccW-1:0]   rsp_num_ff;
   logic [DenW-1:0]   rsp_den_ff;
   logic [CntW-1:0]   rsp_tick_ff, rsp_catchup_ff, rsp_skip_ff, rsp_rebase_ff;

   logic [HzW-1:0]     hz_eff;
   logic [FptEffW-1:0] fpt_eff;
   logic [DenW-1:0]    tu_calc;
   logic [AccW-1:0]    bound_calc;
   logic [GainW-1:0]   gain_in;
   logic [AccW:0]      sum;
   logic               over, is_adv, acc_ge_tu, budget_on, hit_now, rebase_now;
   logic [CntW-1:0]    catchup_add;

   // Effective field rate, tick size and rebase bound.
   always_comb begin
      hz_eff = (cfg.field_rate_hz == '0) ? HzW'(DefaultHz) : cfg.field_rate_hz;
      if (cfg.tick_fields == '0 || cfg.tick_fields > FptW'(MaxFieldsPerTick)) begin
         fpt_eff = FptEffW'(DefaultFpt);
      end else begin
         fpt_eff = FptEffW'(cfg.tick_fields);
      end
      tu_calc    = DenW'(fpt_eff) * DenW'(UnitsPerField);
      bound_calc = AccW'(fpt_eff) * BoundPerField;
   end

   // Gain: scaled nanoseconds or raw units, low accumulator-sized part only.
   assign gain_in = (op_ff == OP_ADV_RAW) ? GainW'(amt_ff[AccW-1:0])
                                          : GainW'(amt_ff[AccW-1:0]) * GainW'(hz_eff);

   // A gain or a sum past the bound rebases; any amount at or above 2^38 is past it.
   always_comb begin
      is_adv     = (op_ff == OP_ADV_NS) || (op_ff == OP_ADV_RAW);
      sum        = (AccW + 1)'(acc_ff) + (AccW + 1)'(gain_ff[AccW-1:0]);
      over       = big_ff || (gain_ff > GainW'(bound_ff)) || (sum > (AccW + 1)'(bound_ff));
      rebase_now = (op_ff == OP_REBASE) || (is_adv && over);
   end

   // Tick loop status.
   always_comb begin
      acc_ge_tu      = acc_ff >= AccW'(tu_ff);
      budget_on      = cfg.step_budget != '0;
      hit_now        = budget_on && acc_ge_tu;
      status.advance = is_adv && !over;
      status.can_sub = acc_ge_tu && (!budget_on || BudgetW'(steps_ff) != cfg.step_budget);
      catchup_add    = (steps_ff > StepW'(1)) ? CntW'(steps_ff) - CntW'(1) : '0;
   end

   // Accumulator and wrapping counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         tick_cnt_ff    <= '0;
         catchup_cnt_ff <= '0;
         skip_cnt_ff    <= '0;
         rebase_cnt_ff  <= '0;
      end else begin
         if (cmd.check) begin
            if (rebase_now) begin
               acc_ff        <= '0;
               rebase_cnt_ff <= rebase_cnt_ff + CntW'(1);
            end else if (status.advance) begin
               acc_ff <= sum[AccW-1:0];
            end
         end
         if (cmd.sub) begin
            acc_ff <= acc_ff - AccW'(tu_ff);
         end
         if (cmd.close) begin
            tick_cnt_ff    <= tick_cnt_ff + CntW'(steps_ff);
            catchup_cnt_ff <= catchup_cnt_ff + catchup_add;
            skip_cnt_ff    <= skip_cnt_ff + CntW'(hit_now);
         end
      end
   end

   // Working registers of the request in flight.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_opcode);
         amt_ff   <= req_amount;
         tu_ff    <= tu_calc;
         bound_ff <= bound_calc;
      end
      if (cmd.mul) begin
         gain_ff <= gain_in;
         big_ff  <= |amt_ff[AmountW-1:AccW];
      end
      if (cmd.check) begin
         rebased_ff <= rebase_now;
         hit_ff     <= 1'b0;
         steps_ff   <= '0;
      end
      if (cmd.sub) begin
         steps_ff <= steps_ff + StepW'(1);
      end
      if (cmd.close) begin
         hit_ff <= hit_now;
      end
   end

   // Result register, loaded when the response slot is free.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_steps_ff   <= (32'(steps_ff) > 32'(StepsMax)) ? StepsW'(StepsMax)
                                                           : StepsW'(steps_ff);
         rsp_rebased_ff <= rebased_ff;
         rsp_hit_ff     <= hit_ff;
         rsp_debt_ff    <= acc_ge_tu;
         rsp_num_ff     <= acc_ge_tu ? '0 : acc_ff;
         rsp_den_ff     <= tu_ff;
         rsp_tick_ff    <= tick_cnt_ff;
         rsp_catchup_ff <= catchup_cnt_ff;
         rsp_skip_ff    <= skip_cnt_ff;
         rsp_rebase_ff  <= rebase_cnt_ff;
      end
   end

   assign rsp_steps         = rsp_steps_ff;
   assign rsp_rebased       = rsp_rebased_ff;
   assign rsp_budget_hit    = rsp_hit_ff;
   assign rsp_has_debt      = rsp_debt_ff;
   assign rsp_alpha_num     = rsp_num_ff;
   assign rsp_alpha_den     = rsp_den_ff;
   assign rsp_tick_total    = rsp_tick_ff;
   assign rsp_catchup_total = rsp_catchup_ff;
   assign rsp_skip_total    = rsp_skip_ff;
   assign rsp_rebase_total  = rsp_rebase_ff;

endmodule

FILE: src/fixed_timestep_accumulator_top.sv
// Fixed-timestep tick scheduler.
// req_ch carries one request: opcode (advance by nanoseconds, advance by raw units,
// rebase, or no operation) and a 64-bit amount. rsp_ch returns exactly one result per
// request: ticks issued, rebase and budget flags, interpolation numerator and
// denominator, and the four wrapping counters. csr_ch writes field_rate_hz (index 0),
// the number of fields in a tick (index 1) and step_budget (index 2); it is always
// ready. The user must see that it is written only while no request is in flight;
// the block itself does not enforce this. One request is worked on at a time.
// A rebase, a no-operation or an advance that rebases passes through ST_MUL, ST_CHECK
// and ST_OUT; an advance that issues n ticks also passes through ST_STEP, where one
// shared subtractor removes one tick per cycle (n is at most REBASE_TICKS). req_ch is
// ready again the cycle after the result is loaded into the output register.
// If the receiver stalls, the result holds in the output register and the next request
// is taken and worked on; its result waits until the held one is taken.
// Reset clears the accumulator and the counters and loads the register defaults:
// 60 Hz, 2 fields per tick, no step budget.
module fixed_timestep_accumulator_top import fta_pkg::*; #(
   parameter int unsigned REBASE_TICKS = RebaseTicksDefault
) (
   input logic        clock,
   input logic        reset,
   fta_req_if.sink    req_ch,
   fta_rsp_if.source  rsp_ch,
   fta_csr_if.sink    csr_ch
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   fta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .csr_ready (csr_ch.ready),
      .cfg       (cfg)
   );

   // Sequencer.
   fta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Accumulator, tick loop and result register.
   fta_dp #(
      .REBASE_TICKS (REBASE_TICKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_ch.opcode),
      .req_amount        (req_ch.amount),
      .rsp_steps         (rsp_ch.steps),
      .rsp_rebased       (rsp_ch.rebased),
      .rsp_budget_hit    (rsp_ch.budget_hit),
      .rsp_has_debt      (rsp_ch.has_debt),
      .rsp_alpha_num     (rsp_ch.alpha_num),
      .rsp_alpha_den     (rsp_ch.alpha_den),
      .rsp_tick_total    (rsp_ch.tick_total),
      .rsp_catchup_total (rsp_ch.catchup_total),
      .rsp_skip_total    (rsp_ch.skip_total),
      .rsp_rebase_total  (rsp_ch.rebase_total)
   );

endmodule

FILE: src/fta_checker.sv
`include "fixed_timestep_accumulator_top_assert.svh"

module fta_checker import fta_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [StepsW-1:0] rsp_steps,
   input logic              rsp_rebased,
   input logic              rsp_budget_hit,
   input logic              rsp_has_debt,
   input logic [AccW-1:0]   rsp_alpha_num
);

   // A stalled result stays offered.
   `FTA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // Only one request is in flight: acceptance closes the request side.
   `FTA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // While a whole tick remains, the interpolation numerator reads zero.
   `FTA_ASSERT_SAME(a_debt_num, rsp_valid && rsp_has_debt, rsp_alpha_num == '0)

   // A rebase issues no ticks and leaves nothing owed.
   `FTA_ASSERT_SAME(a_rebase_clean, rsp_valid && rsp_rebased,
                    rsp_steps == '0 && !rsp_budget_hit && !rsp_has_debt)

   // The budget only stops ticks while a whole tick is still owed.
   `FTA_ASSERT_SAME(a_hit_debt, rsp_valid && rsp_budget_hit, rsp_has_debt)

endmodule

bind fixed_timestep_accumulator_top fta_checker u_fta_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_steps      (rsp_ch.steps),
   .rsp_rebased    (rsp_ch.rebased),
   .rsp_budget_hit (rsp_ch.budget_hit),
   .rsp_has_debt   (rsp_ch.has_debt),
   .rsp_alpha_num  (rsp_ch.alpha_num)
);

FILE: test/fixed_timestep_accumulator_top_tb.sv
`timescale 1ns / 100ps

module fixed_timestep_accumulator_top_tb;
   import fta_pkg::*;

   localparam int unsigned RebaseLimit    = RebaseTicksDefault;
   localparam logic [63:0] AllOnes        = '1;
   localparam int unsigned RunLimitCycles = 600000;
   localparam int unsigned SettleCycles   = 40;
   // Index 3 on the configuration port names no register.
   localparam logic [CsrIdxW-1:0] CsrSpare = 2'd3;

   // One response as it appears on the result channel.
   typedef struct packed {
      logic [StepsW-1:0] steps;
      logic              rebased;
      logic              budget_hit;
      logic              has_debt;
      logic [AccW-1:0]   alpha_num;
      logic [DenW-1:0]   alpha_den;
      logic [CntW-1:0]   tick_total;
      logic [CntW-1:0]   catchup_total;
      logic [CntW-1:0]   skip_total;
      logic [CntW-1:0]   rebase_total;
   } tick_report_type;

   // Tick schedule predictor and the queue of reports still to come.
   class tick_scoreboard;
      logic [HzW-1:0]     rate_reg;
      logic [FptW-1:0]    fpt_reg;
      logic [BudgetW-1:0] budget_reg;
      logic [63:0]        accumulator;
      logic [CntW-1:0]    tick_count;
      logic [CntW-1:0]    catchup_count;
      logic [CntW-1:0]    skip_count;
      logic [CntW-1:0]    rebase_count;
      tick_report_type    expected_reports[$];
      int unsigned        mismatches;

      function new();
         rate_reg      = ResetHz;
         fpt_reg       = ResetFpt;
         budget_reg    = ResetBudget;
         accumulator   = '0;
         tick_count    = '0;
         catchup_count = '0;
         skip_count    = '0;
         rebase_count  = '0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] data);
         case (index)
            CsrFieldRate:  rate_reg   = data[HzW-1:0];
            CsrFieldsTick: fpt_reg    = data[FptW-1:0];
            CsrStepBudget: budget_reg = data[BudgetW-1:0];
            default: ;
         endcase
      endfunction

      // Units in one tick; out-of-range field counts fall back to the default.
      function logic [63:0] units_in_tick();
         logic [63:0] fields;
         fields = 64'(fpt_reg);
         if (fpt_reg < 1 || fpt_reg > MaxFieldsPerTick) fields = 64'(DefaultFpt);
         return fields * UnitsPerField;
      endfunction

      function logic [63:0] rate();
         return (rate_reg == '0) ? 64'(DefaultHz) : 64'(rate_reg);
      endfunction

      function int unsigned pending();
         return expected_reports.size();
      endfunction

      // Applies one request to the tick state and returns the report it causes.
      function tick_report_type advance(logic [OpW-1:0] opcode, logic [63:0] amount);
         tick_report_type rpt;
         logic [63:0]     tu;
         logic [63:0]     bound;
         logic [63:0]     gained;
         logic [63:0]     whole;
         logic [63:0]     steps;
         logic            clear;
         logic            hit;
         tu     = units_in_tick();
         bound  = 64'(RebaseLimit) * tu;
         gained = '0;
         steps  = '0;
         clear  = 1'b0;
         hit    = 1'b0;
         case (op_type'(opcode))
            OP_REBASE: clear = 1'b1;
            OP_ADV_NS, OP_ADV_RAW: begin
               // Nanoseconds are scaled by the field rate unless the product overflows.
               if (op_type'(opcode) == OP_ADV_NS) begin
                  if (amount > AllOnes / rate()) clear = 1'b1;
                  else gained = amount * rate();
               end else begin
                  gained = amount;
               end
               if (!clear && gained > bound) clear = 1'b1;
               if (!clear && gained > AllOnes - accumulator) clear = 1'b1;
               if (!clear && accumulator + gained > bound) clear = 1'b1;
               // Take whole ticks, no more than the budget allows.
               if (!clear) begin
                  accumulator = accumulator + gained;
                  whole = accumulator / tu;
                  if (budget_reg != '0 && whole > 64'(budget_reg)) begin
                     steps = 64'(budget_reg);
                     hit = 1'b1;
                     skip_count = skip_count + 1'b1;
                  end else begin
                     steps = whole;
                  end
                  accumulator = accumulator - steps * tu;
                  tick_count = tick_count + steps[CntW-1:0];
                  if (steps > 1) catchup_count = catchup_count + CntW'(steps - 64'd1);
               end
            end
            default: ;
         endcase
         if (clear) begin
            accumulator = '0;
            rebase_count = rebase_count + 1'b1;
         end
         accumulator = 64'(accumulator[AccW-1:0]);

         rpt.has_debt      = (accumulator >= tu);
         rpt.steps         = (steps > StepsMax) ? StepsW'(StepsMax) : steps[StepsW-1:0];
         rpt.rebased       = clear;
         rpt.budget_hit    = hit;
         rpt.alpha_num     = rpt.has_debt ? '0 : accumulator[AccW-1:0];
         rpt.alpha_den     = tu[DenW-1:0];
         rpt.tick_total    = tick_count;
         rpt.catchup_total = catchup_count;
         rpt.skip_total    = skip_count;
         rpt.rebase_total  = rebase_count;
         return rpt;
      endfunction

      function void note_request(logic [OpW-1:0] opcode, logic [63:0] amount);
         expected_reports.push_back(advance(opcode, amount));
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t ns: %s", $time, what);
      endfunction

      // Compares one response with the oldest expected report.
      function void check_result(tick_report_type got);
         tick_report_type want;
         if (expected_reports.size() == 0) begin
            flag("response arrived with no request outstanding");
            return;
         end
         want = expected_reports.pop_front();
         if (got.steps !== want.steps)
            flag($sformatf("steps: expected %0d, got %0d", want.steps, got.steps));
         if (got.rebased !== want.rebased)
            flag($sformatf("rebased: expected %0d, got %0d", want.rebased, got.rebased));
         if (got.budget_hit !== want.budget_hit)
            flag($sformatf("budget_hit: expected %0d, got %0d",
                           want.budget_hit, got.budget_hit));
         if (got.has_debt !== want.has_debt)
            flag($sformatf("has_debt: expected %0d, got %0d", want.has_debt, got.has_debt));
         if (got.alpha_num !== want.alpha_num)
            flag($sformatf("alpha_num: expected %0d, got %0d",
                           want.alpha_num, got.alpha_num));
         if (got.alpha_den !== want.alpha_den)
            flag($sformatf("alpha_den: expected %0d, got %0d",
                           want.alpha_den, got.alpha_den));
         if (got.tick_total !== want.tick_total)
            flag($sformatf("tick_total: expected %0d, got %0d",
                           want.tick_total, got.tick_total));
         if (got.catchup_total !== want.catchup_total)
            flag($sformatf("catchup_total: expected %0d, got %0d",
                           want.catchup_total, got.catchup_total));
         if (got.skip_total !== want.skip_total)
            flag($sformatf("skip_total: expected %0d, got %0d",
                           want.skip_total, got.skip_total));
         if (got.rebase_total !== want.rebase_total)
            flag($sformatf("rebase_total: expected %0d, got %0d",
                           want.rebase_total, got.rebase_total));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady;
   int unsigned     hold_left;
   tick_report_type seen;
   tick_scoreboard  sb;

   fta_req_if req_ch ();
   fta_rsp_if rsp_ch ();
   fta_csr_if csr_ch ();

   fixed_timestep_accumulator_top #(
      .REBASE_TICKS(RebaseLimit)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // Idle length for either side: mostly short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [63:0] rand_upto(logic [63:0] top);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if (top == AllOnes) return raw;
      return raw % (top + 64'd1);
   endfunction

   // Result side: check each accepted response, then stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.steps         = rsp_ch.steps;
            seen.rebased       = rsp_ch.rebased;
            seen.budget_hit    = rsp_ch.budget_hit;
            seen.has_debt      = rsp_ch.has_debt;
            seen.alpha_num     = rsp_ch.alpha_num;
            seen.alpha_den     = rsp_ch.alpha_den;
            seen.tick_total    = rsp_ch.tick_total;
            seen.catchup_total = rsp_ch.catchup_total;
            seen.skip_total    = rsp_ch.skip_total;
            seen.rebase_total  = rsp_ch.rebase_total;
            sb.check_result(seen);
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold_left <= pick_gap();
         end
      end
   end

   // Sends one request after a random gap and records it once accepted.
   task automatic send_request(op_type op, logic [63:0] amount);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.amount <= amount;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, amount);
   endtask

   // Holds off new requests until every expected response has been taken.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(index, data);
   endtask

   // Writes all registers while the block is idle.
   task automatic configure(logic [HzW-1:0] hz, logic [FptW-1:0] fpt,
                            logic [BudgetW-1:0] budget, bit with_spare);
      drain();
      write_reg(CsrFieldRate, CsrDataW'(hz));
      write_reg(CsrFieldsTick, CsrDataW'(fpt));
      write_reg(CsrStepBudget, CsrDataW'(budget));
      if (with_spare) write_reg(CsrSpare, '1);
      csr_ch.valid <= 1'b0;
   endtask

   // One random request, weighted toward ordinary frame times.
   task automatic send_random(output bit counts);
      int unsigned pick;
      logic [63:0] tu;
      logic [63:0] hz;
      logic [63:0] bound;
      tu     = sb.units_in_tick();
      hz     = sb.rate();
      bound  = 64'(RebaseLimit) * tu;
      pick   = $urandom_range(99);
      counts = 1'b1;
      if (pick < 40) send_request(OP_ADV_NS, rand_upto(2 * tu / hz));
      else if (pick < 50) send_request(OP_ADV_NS, rand_upto(bound / hz));
      else if (pick < 53) send_request(OP_ADV_NS, bound / hz + 64'($urandom_range(1)));
      else if (pick < 56) send_request(OP_ADV_NS, {$urandom, $urandom});
      else if (pick < 58) send_request(OP_ADV_NS, AllOnes / hz + 64'($urandom_range(1)));
      else if (pick < 78) send_request(OP_ADV_RAW, rand_upto(2 * tu));
      else if (pick < 85) send_request(OP_ADV_RAW, rand_upto(bound));
      else if (pick < 88) send_request(OP_ADV_RAW, bound - 64'd1 + 64'($urandom_range(2)));
      else if (pick < 91) send_request(OP_ADV_RAW, {$urandom, $urandom});
      else if (pick < 95) send_request(OP_REBASE, {$urandom, $urandom});
      else begin
         send_request(OP_NOP, {$urandom, $urandom});
         counts = 1'b0;
      end
   endtask

   initial begin
      logic [HzW-1:0]     hz_list[8];
      logic [FptW-1:0]    fpt_list[8];
      logic [BudgetW-1:0] budget_list[8];
      int unsigned        counted;
      int unsigned        failures;
      bit                 counts;

      sb = new();
      reset         = 1'b1;
      steady        = 1'b0;
      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_NOP;
      req_ch.amount = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CsrFieldRate;
      csr_ch.data   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fresh state, then requests that land exactly on tick boundaries.
      send_request(OP_NOP, 64'd0);
      send_request(OP_ADV_NS, 64'd0);
      send_request(OP_ADV_RAW, 64'd1999999999);
      send_request(OP_ADV_RAW, 64'd1);
      send_request(OP_ADV_RAW, 64'd2000000000);
      send_request(OP_ADV_NS, 64'd33333334);
      // Filling the accumulator exactly to the rebase bound issues every tick at once.
      send_request(OP_ADV_RAW, 64'd59999999960);
      // A single gain above the bound, and a sum above it.
      send_request(OP_ADV_RAW, 64'd60000000001);
      send_request(OP_ADV_RAW, 64'd1500000000);
      send_request(OP_ADV_RAW, 64'd59000000000);
      // Scaled products right at and past the 64-bit overflow point.
      send_request(OP_ADV_NS, AllOnes / 64'd60 + 64'd1);
      send_request(OP_ADV_NS, AllOnes / 64'd60);
      send_request(OP_ADV_NS, AllOnes);
      send_request(OP_REBASE, AllOnes);
      send_request(OP_NOP, AllOnes);

      // A budget of one leaves debt behind and counts a skip.
      configure(60, 2, 1, 1'b0);
      send_request(OP_ADV_RAW, 64'd5000000000);
      send_request(OP_NOP, 64'd0);
      send_request(OP_ADV_RAW, 64'd0);

      // Large debt under long ticks, then a shorter tick size and a lower bound.
      configure(0, 6, 1, 1'b0);
      send_request(OP_ADV_RAW, 64'd170000000000);
      configure(1023, 1, 0, 1'b1);
      send_request(OP_NOP, 64'd0);
      send_request(OP_ADV_NS, 64'd0);

      // Random phases over a spread of register settings.
      hz_list     = '{60, 0, 1000, 1, 1023, 250, 0, 0};
      fpt_list    = '{2, 0, 6, 1, 15, 7, 0, 0};
      budget_list = '{0, 0, 255, 1, 3, 0, 0, 0};
      for (int p = 6; p < 8; p++) begin
         hz_list[p]     = HzW'($urandom_range(1023));
         fpt_list[p]    = FptW'($urandom_range(15));
         budget_list[p] = BudgetW'($urandom_range(255));
      end
      for (int p = 0; p < 8; p++) begin
         configure(hz_list[p], fpt_list[p], budget_list[p], 1'b0);
         steady = (p == 3) || ($urandom_range(3) == 0);
         counted = 0;
         while (counted < 50) begin
            send_random(counts);
            if (counts) counted++;
            if ($urandom_range(39) == 0) drain();
         end
      end

      // Let the last responses arrive and make sure nothing extra follows.
      steady = 1'b0;
      drain();
      repeat (SettleCycles) @(posedge clock);
      failures = sb.mismatches + sb.pending();
      if (failures == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      repeat (RunLimitCycles) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
